// ===== sv/ais_pkg.sv =====
// ----------------------------------------------------------------------------
// ais_pkg
// Shared types and constants for the array insert/shift store: command and
// result words, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package ais_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  // Default number of stored elements.
  localparam int unsigned CAPACITY_DEF = 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    func_e                     func;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } ais_cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        count;
    status_e                   status;
  } ais_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_READ_OUT
  } ais_state_e;

endpackage

// ===== sv/array_insert_shift_store_core.sv =====
// ----------------------------------------------------------------------------
// array_insert_shift_store_core
// Ordered store of signed 32-bit words with append, insert-with-shift and read.
// ----------------------------------------------------------------------------
// Rejects and the unused selector finish in the execute state; append and
// read pass through the put or read-out state; an insert below the end
// primes the read pipe and shifts before the put. The single memory port
// pair sets the shift pace of one element per cycle. The next word is taken
// in the cycle done_o is high, not while busy. The receiver cannot stall results.
// Reset clears the element count and the sequencer; the element memory is
// not cleared, since only entries below the count are ever read.
module array_insert_shift_store_core #(
  parameter int unsigned CAPACITY = ais_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ais_pkg::ais_cmd_t    cmd_i,
  output logic                done_o,
  output ais_pkg::ais_result_t result_o
);
  import ais_pkg::*;

  // Address width for the memory and count width able to hold CAPACITY.
  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  // Width at which positions and counts are compared without loss.
  localparam int unsigned CmpW  = (CntW > POS_W) ? CntW : POS_W;

  // Element memory: one write port and one registered read port.
  logic [VALUE_W-1:0] mem [CAPACITY];
  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [AddrW-1:0]   mem_raddr;
  logic [VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Sequencer state, element count and the latched command.
  ais_state_e         state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [AddrW-1:0]   idx_q, idx_d;
  logic               done_q, done_d;
  ais_result_t        result_q, result_d;
  func_e              func_q;
  logic [CmpW-1:0]    pos_q;
  logic [VALUE_W-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    result_q <= result_d;
    if (start && !busy) begin
      func_q <= cmd_i.func;
      pos_q  <= CmpW'(cmd_i.position);
      val_q  <= cmd_i.value;
    end
  end

  logic            full;
  logic [CmpW-1:0] cnt_w;
  assign full  = (count_q == CntW'(CAPACITY));
  assign cnt_w = CmpW'(count_q);

  // Next state and datapath control. A finished word is registered into
  // result_q/done_q and the sequencer returns to idle in the same edge.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    done_d    = 1'b0;
    result_d  = result_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = val_q;
    mem_raddr = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        // Default finish for rejects and the unused selector.
        result_d.read_value = '0;
        result_d.count      = COUNT_W'(count_q);
        result_d.status     = STATUS_OK;
        unique case (func_q)
          FUNC_APPEND: begin
            if (full) begin
              result_d.status = STATUS_FULL;
              done_d          = 1'b1;
              state_d         = ST_IDLE;
            end else begin
              idx_d   = AddrW'(count_q);
              state_d = ST_PUT;
            end
          end
          FUNC_INSERT: begin
            priority if (full) begin
              result_d.status = STATUS_FULL;
              done_d          = 1'b1;
              state_d         = ST_IDLE;
            end else if (pos_q > cnt_w) begin
              result_d.status = STATUS_RANGE;
              done_d          = 1'b1;
              state_d         = ST_IDLE;
            end else if (pos_q == cnt_w) begin
              // Insert at the end: nothing to move.
              idx_d   = AddrW'(pos_q);
              state_d = ST_PUT;
            end else begin
              // Start the shift at the last element and walk down.
              idx_d   = AddrW'(count_q - CntW'(1));
              state_d = ST_SHIFT_RD;
            end
          end
          FUNC_READ: begin
            if (pos_q >= cnt_w) begin
              result_d.read_value = '1;
              result_d.status     = STATUS_RANGE;
              done_d              = 1'b1;
              state_d             = ST_IDLE;
            end else begin
              mem_raddr = AddrW'(pos_q);
              state_d   = ST_READ_OUT;
            end
          end
          FUNC_NOP: begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
          default: begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_SHIFT_RD: begin
        // Prime the read pipe with the top element.
        mem_raddr = idx_q;
        state_d   = ST_SHIFT_WR;
      end

      ST_SHIFT_WR: begin
        // Move element idx up by one while fetching the one below it.
        mem_we    = 1'b1;
        mem_waddr = idx_q + AddrW'(1);
        mem_wdata = rdata_q;
        mem_raddr = idx_q - AddrW'(1);
        if (idx_q == AddrW'(pos_q)) begin
          state_d = ST_PUT;
        end else begin
          idx_d = idx_q - AddrW'(1);
        end
      end

      ST_PUT: begin
        mem_we              = 1'b1;
        mem_waddr           = idx_q;
        mem_wdata           = val_q;
        count_d             = count_q + CntW'(1);
        result_d.read_value = '0;
        result_d.count      = COUNT_W'(count_q + CntW'(1));
        result_d.status     = STATUS_OK;
        done_d              = 1'b1;
        state_d             = ST_IDLE;
      end

      ST_READ_OUT: begin
        result_d.read_value = rdata_q;
        result_d.count      = COUNT_W'(count_q);
        result_d.status     = STATUS_OK;
        done_d              = 1'b1;
        state_d             = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== sv/ais_checker.sv =====
// ----------------------------------------------------------------------------
// ais_checker
// Port-level checks for the array insert/shift store, bound to the top level.
// ----------------------------------------------------------------------------
module ais_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 done_i,
  input ais_pkg::ais_result_t result_i
);
  import ais_pkg::*;

  // Every accepted word raises busy in the cycle after it is taken.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted word");

  // A result only follows a busy cycle.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(busy))
    else $error("result strobe without preceding work");

  // Results never come back to back.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i)
    else $error("result strobe held for two cycles");

  // A write rejected as full returns zero as its read value.
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && result_i.status == STATUS_FULL) |-> (result_i.read_value == 0))
    else $error("full status with nonzero read value");

endmodule

bind array_insert_shift_store_core ais_checker u_ais_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_i   (done_o),
  .result_i (result_o)
);

// ===== dv/array_insert_shift_store_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_insert_shift_store_checker
// Watches the command and result channels of the store, keeps its own copy
// of the element array and count, and compares every result with the word
// predicted for the oldest accepted command.
// ----------------------------------------------------------------------------
module array_insert_shift_store_checker #(
  parameter int unsigned CAPACITY = ais_pkg::CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  ais_pkg::ais_cmd_t    cmd_i,
  input  logic                 done_i,
  input  ais_pkg::ais_result_t result_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          outstanding_o
);
  import ais_pkg::*;

  logic signed [VALUE_W-1:0] cells [CAPACITY];
  int unsigned               fill;
  ais_result_t               result_q [$];

  // Applies one command to the shadow store and returns the result word.
  function automatic ais_result_t apply_word(input ais_cmd_t w);
    ais_result_t r;
    int unsigned k;
    r.read_value = '0;
    r.status     = STATUS_OK;
    case (w.func)
      FUNC_APPEND: begin
        if (fill >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          cells[fill] = w.value;
          fill++;
        end
      end
      FUNC_INSERT: begin
        if (fill >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else if (w.position > fill) begin
          r.status = STATUS_RANGE;
        end else begin
          for (k = fill; k > w.position; k--) cells[k] = cells[k-1];
          cells[w.position] = w.value;
          fill++;
        end
      end
      FUNC_READ: begin
        if (w.position >= fill) begin
          r.read_value = -1;
          r.status     = STATUS_RANGE;
        end else begin
          r.read_value = cells[w.position];
        end
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(fill);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ais_result_t want;
    int unsigned bad;
    if (!rst_ni) begin
      result_q.delete();
      fill = 0;
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      bad = 0;
      if (done_i === 1'b1) begin
        if (result_q.size() == 0) begin
          bad = 1;
          $display("%0t: result expected none actual %p", $time, result_i);
        end else begin
          want = result_q.pop_front();
          if (result_i.read_value !== want.read_value) begin
            bad = 1;
            $display("%0t: read_value expected %0d actual %0d", $time,
                     want.read_value, result_i.read_value);
          end
          if (result_i.count !== want.count) begin
            bad = 1;
            $display("%0t: count expected %0d actual %0d", $time,
                     want.count, result_i.count);
          end
          if (result_i.status !== want.status) begin
            bad = 1;
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, result_i.status);
          end
        end
      end
      if (bad != 0) mismatch_count_o <= mismatch_count_o + 1;
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        result_q = {result_q, apply_word(cmd_i)};
      end
      outstanding_o <= result_q.size();
    end
  end

endmodule

// ===== dv/array_insert_shift_store_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_insert_shift_store_core_tb
// Drives commands into the ordered word store and lets a checker compare each
// result with its own prediction; prints a single verdict at the end.
// ----------------------------------------------------------------------------
module array_insert_shift_store_core_tb;
  import ais_pkg::*;

  localparam int unsigned CAP       = CAPACITY_DEF;
  localparam int unsigned RAND_WORDS = 2000;
  // Longest latency is an insert at position zero into a store that holds
  // CAPACITY - 1 words; the tail wait covers it with some margin.
  localparam int unsigned TAIL_CYCLES = CAP + 8;
  localparam int unsigned DRAIN_LIMIT = 2000;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        start    = 1'b0;
  logic        busy;
  ais_cmd_t    cmd_word = '0;
  logic        done_o;
  ais_result_t result_o;

  int unsigned mismatches;
  int unsigned outstanding;

  // Percentage of cycles in which the sender holds back its next word.
  int unsigned idle_pct;
  // Number of stored words as the stimulus sees it. It only steers the
  // choice of commands and positions so that most inserts and reads land in range.
  int unsigned level;

  always #5 clk_i = ~clk_i;

  array_insert_shift_store_core #(
    .CAPACITY(CAP)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_word),
    .done_o  (done_o),
    .result_o(result_o)
  );

  array_insert_shift_store_checker #(
    .CAPACITY(CAP)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .cmd_i           (cmd_word),
    .done_i          (done_o),
    .result_i        (result_o),
    .mismatch_count_o(mismatches),
    .outstanding_o   (outstanding)
  );

  // Presents one command word and holds it until the store takes it, which
  // happens at the first rising edge that sees start high and busy low. The
  // task returns in that step unless a break follows; when none does, start
  // simply stays high and the next call puts the next word on the bus, so
  // start is never lowered and raised within one step.
  task automatic send_word(input func_e f, input logic [POS_W-1:0] p,
                           input logic [VALUE_W-1:0] v);
    start    <= 1'b1;
    cmd_word <= '{func: f, position: p, value: v};
    do @(posedge clk_i); while (busy !== 1'b0);
    if (f == FUNC_APPEND && level < CAP) begin
      level++;
    end else if (f == FUNC_INSERT && level < CAP && p <= level) begin
      level++;
    end
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every expected result has come back or the
  // limit is reached. The first edge lets the checker count the word accepted last.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // One random command. While the store has room, close to half the words
  // are well-formed writes at a valid position, so the shift path is exercised
  // at every depth. Once it is full, most words are reads of stored entries
  // and the writes that remain all hit the full case. A share of raw noise
  // covers the unused selector and positions up to the top of the field.
  task automatic random_word();
    int unsigned pick;
    logic [VALUE_W-1:0] v;
    pick = $urandom_range(0, 99);
    v    = $urandom();
    if (pick < 15) begin
      send_word(func_e'(FUNC_W'($urandom_range(0, 3))),
                POS_W'($urandom_range(0, 31)), v);
    end else if (level < CAP && pick < 60) begin
      if ($urandom_range(0, 3) == 0) begin
        send_word(FUNC_APPEND, POS_W'($urandom_range(0, 31)), v);
      end else begin
        send_word(FUNC_INSERT, POS_W'($urandom_range(0, level)), v);
      end
    end else if (pick < 90) begin
      send_word(FUNC_READ, POS_W'($urandom_range(0, (level > 0) ? level - 1 : 0)), v);
    end else begin
      send_word(FUNC_READ, POS_W'($urandom_range(level, 31)), v);
    end
  endtask

  // Hard stop in case the store hangs or never raises done_o.
  initial begin
    #5_000_000;
    $display("array_insert_shift_store_core_tb: errors");
    $finish;
  end

  initial begin
    int unsigned n;
    idle_pct = 37;
    level    = 0;

    // Reset is held low from the start and released at a rising edge.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words on an empty store: a read and an insert past the end
    // are both out of range, and the unused selector changes nothing.
    send_word(FUNC_READ,   5'd0,  32'h0000_0000);
    send_word(FUNC_INSERT, 5'd1,  32'h1234_5678);
    send_word(FUNC_NOP,    5'd0,  32'hFFFF_FFFF);
    // Build up a few words with the extreme values, inserting at the front,
    // at the end and in the middle so that the shift moves real data.
    send_word(FUNC_APPEND, 5'd0,  32'h7FFF_FFFF);
    send_word(FUNC_INSERT, 5'd0,  32'h8000_0000);
    send_word(FUNC_INSERT, 5'd2,  32'hFFFF_FFFF);
    send_word(FUNC_INSERT, 5'd1,  32'h0000_0000);
    // An insert one past the count is rejected.
    send_word(FUNC_INSERT, 5'd5,  32'h0BAD_0BAD);
    // Read every stored word, then the first index past the end and the
    // highest index the field can carry.
    send_word(FUNC_READ,   5'd0,  32'h0000_0000);
    send_word(FUNC_READ,   5'd1,  32'hFFFF_FFFF);
    send_word(FUNC_READ,   5'd2,  32'h0000_0000);
    send_word(FUNC_READ,   5'd3,  32'h0000_0000);
    send_word(FUNC_READ,   5'd4,  32'h0000_0000);
    send_word(FUNC_READ,   5'd31, 32'h0000_0000);
    send_word(FUNC_APPEND, 5'd31, 32'h5555_5555);
    send_word(FUNC_INSERT, 5'd3,  32'hAAAA_AAAA);
    send_word(FUNC_READ,   5'd16, 32'h0000_0000);
    send_word(FUNC_READ,   5'd3,  32'h0000_0000);
    send_word(FUNC_READ,   5'd5,  32'h0000_0000);
    send_word(FUNC_NOP,    5'd31, $urandom());

    // Let the store run dry once before the random part starts.
    drain();

    // Random part in three stretches: the sender idles often, then more
    // often, then not at all. The store is drained between stretches.
    for (n = 0; n < RAND_WORDS; n++) begin
      if (n == RAND_WORDS / 3) begin
        drain();
        idle_pct = 66;
      end
      if (n == 2 * RAND_WORDS / 3) begin
        drain();
        idle_pct = 0;
      end
      random_word();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && outstanding == 0) begin
      $display("array_insert_shift_store_core_tb: clean");
    end else begin
      $display("array_insert_shift_store_core_tb: errors");
    end
    $finish;
  end

endmodule

// ===== array_insert_shift_store_core.f =====
sv/ais_pkg.sv
sv/array_insert_shift_store_core.sv
sv/ais_checker.sv
dv/array_insert_shift_store_checker.sv
dv/array_insert_shift_store_core_tb.sv
